// File: rtl/sepq_pkg.sv
`timescale 1ns / 1ps

package sepq_pkg;

   // command codes on the request channel
   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   // status codes on the response channel
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } stat_type;

   // sequencer states
   typedef enum logic [1:0] {
      SEQ_IDLE  = 2'd0,
      SEQ_SCAN  = 2'd1,
      SEQ_FETCH = 2'd2,
      SEQ_LOAD  = 2'd3
   } seq_state_type;

   localparam int FIELD_WIDTH = 32;
   localparam int KIND_WIDTH  = 8;
   localparam int CMD_WIDTH   = 2;
   localparam int STAT_WIDTH  = 2;

endpackage

// File: rtl/sepq_req_if.sv
`timescale 1ns / 1ps

interface sepq_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [sepq_pkg::CMD_WIDTH-1:0]       command;
   logic [sepq_pkg::FIELD_WIDTH-1:0]     event_time;
   logic [sepq_pkg::FIELD_WIDTH-1:0]     event_length;
   logic [sepq_pkg::KIND_WIDTH-1:0]      event_kind;

   modport source (output valid, command, event_time, event_length, event_kind,
                   input ready);
   modport sink   (input valid, command, event_time, event_length, event_kind,
                   output ready);
endinterface

// File: rtl/sepq_rsp_if.sv
`timescale 1ns / 1ps

interface sepq_rsp_if #(
   parameter int COUNT_WIDTH = 5
);
   logic                                 valid;
   logic                                 ready;
   logic [sepq_pkg::STAT_WIDTH-1:0]      status;
   logic                                 head_valid;
   logic [sepq_pkg::FIELD_WIDTH-1:0]     head_time;
   logic [sepq_pkg::FIELD_WIDTH-1:0]     head_length;
   logic [sepq_pkg::KIND_WIDTH-1:0]      head_kind;
   logic [COUNT_WIDTH-1:0]               entry_count;

   modport source (output valid, status, head_valid, head_time, head_length, head_kind,
                   entry_count, input ready);
   modport sink   (input valid, status, head_valid, head_time, head_length, head_kind,
                   entry_count, output ready);
endinterface

// File: rtl/sorted_event_priority_queue_unit.sv
`timescale 1ns / 1ps

// sorted event priority queue: holds up to DEPTH events (time, length, kind)
// in ascending time order in a circular buffer memory
// req_chan carries a command (push, pop, clear) plus the event to push;
// rsp_chan returns one result per request: status, head event after the
// command, a head-valid flag and the entry count
// a transfer on either channel happens when valid and ready are both high
// sequence: a pop, clear or rejected command goes from idle through the fetch and
// load states; a push that moves k stored events up one place first runs the
// insertion scan, which reads one entry per cycle from the single memory read
// port and compares it with the one time comparator, then fetch and load
// for either, the result is registered in the load state and shows up in the
// cycle the block turns idle again
// reset (synchronous, active high) empties the queue and drops any pending
// result; the memory contents are not cleared and need no clearing pass
// when the receiver stalls, the result register holds; one further request
// can be accepted and worked on, and its result waits until the held one
// has been transferred
module sorted_event_priority_queue_unit #(
   parameter int DEPTH      = 16,
   parameter int TIME_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   sepq_req_if.sink    req_chan,
   sepq_rsp_if.source  rsp_chan
);
   import sepq_pkg::*;

   // stored key width: the time field is 32 bits on the port
   localparam int SW = (TIME_WIDTH < FIELD_WIDTH) ? TIME_WIDTH : FIELD_WIDTH;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   // circular pointer steps
   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      return (p == LAST_ADDR) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
      return (p == '0) ? LAST_ADDR : p - 1'b1;
   endfunction

   // sequencer and queue bookkeeping
   seq_state_type    state_ff, state_in;
   logic [AW-1:0]    head_ff, head_in;     // physical slot of the head event
   logic [AW-1:0]    tail_ff, tail_in;     // physical slot just past the last event
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    left_ff, left_in;     // events still in front of the write slot
   logic [AW-1:0]    ptr_ff, ptr_in;       // slot being written during the scan
   stat_type         status_ff, status_in;

   // event being inserted
   logic [SW-1:0]          time_ff, time_in;
   logic [FIELD_WIDTH-1:0] length_ff, length_in;
   logic [KIND_WIDTH-1:0]  kind_ff, kind_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   stat_type               rsp_status_ff, rsp_status_in;
   logic                   rsp_head_valid_ff, rsp_head_valid_in;
   logic [FIELD_WIDTH-1:0] rsp_time_ff, rsp_time_in;
   logic [FIELD_WIDTH-1:0] rsp_length_ff, rsp_length_in;
   logic [KIND_WIDTH-1:0]  rsp_kind_ff, rsp_kind_in;
   logic [CW-1:0]          rsp_count_ff, rsp_count_in;

   // memory ports
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [SW-1:0]          wr_time;
   logic [FIELD_WIDTH-1:0] wr_length;
   logic [KIND_WIDTH-1:0]  wr_kind;
   logic [AW-1:0]          rd_addr;
   logic [SW-1:0]          rd_time;
   logic [FIELD_WIDTH-1:0] rd_length;
   logic [KIND_WIDTH-1:0]  rd_kind;

   // the shared compare unit: does the stored event stay behind the new one
   logic                   move_up;
   logic                   rsp_free;

   sepq_store #(
      .DEPTH (DEPTH),
      .SW    (SW)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_time   (wr_time),
      .wr_length (wr_length),
      .wr_kind   (wr_kind),
      .rd_addr   (rd_addr),
      .rd_time   (rd_time),
      .rd_length (rd_length),
      .rd_kind   (rd_kind)
   );

   assign move_up  = (left_ff != '0) && (rd_time >= time_ff);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      left_ff           <= left_in;
      ptr_ff            <= ptr_in;
      status_ff         <= status_in;
      time_ff           <= time_in;
      length_ff         <= length_in;
      kind_ff           <= kind_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_head_valid_ff <= rsp_head_valid_in;
      rsp_time_ff       <= rsp_time_in;
      rsp_length_ff     <= rsp_length_in;
      rsp_kind_ff       <= rsp_kind_in;
      rsp_count_ff      <= rsp_count_in;
   end

   always_comb begin
      state_in          = state_ff;
      head_in           = head_ff;
      tail_in           = tail_ff;
      count_in          = count_ff;
      left_in           = left_ff;
      ptr_in            = ptr_ff;
      status_in         = status_ff;
      time_in           = time_ff;
      length_in         = length_ff;
      kind_in           = kind_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in     = rsp_status_ff;
      rsp_head_valid_in = rsp_head_valid_ff;
      rsp_time_in       = rsp_time_ff;
      rsp_length_in     = rsp_length_ff;
      rsp_kind_in       = rsp_kind_ff;
      rsp_count_in      = rsp_count_ff;
      req_chan.ready    = 1'b0;
      wr_en             = 1'b0;
      wr_addr           = ptr_ff;
      wr_time           = time_ff;
      wr_length         = length_ff;
      wr_kind           = kind_ff;
      rd_addr           = head_ff;

      unique case (state_ff)
         SEQ_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               status_in = STAT_OK;
               state_in  = SEQ_FETCH;
               unique case (cmd_type'(req_chan.command))
                  CMD_PUSH: begin
                     if (count_ff == FULL_COUNT) begin
                        status_in = STAT_FULL;
                     end else begin
                        time_in   = req_chan.event_time[SW-1:0];
                        length_in = req_chan.event_length;
                        kind_in   = req_chan.event_kind;
                        left_in   = count_ff;
                        ptr_in    = tail_ff;
                        // prefetch the last stored event
                        rd_addr   = ptr_dec(tail_ff);
                        state_in  = SEQ_SCAN;
                     end
                  end
                  CMD_POP: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        head_in  = ptr_inc(head_ff);
                        count_in = count_ff - 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     head_in  = '0;
                     tail_in  = '0;
                     count_in = '0;
                  end
                  default: begin
                     // unused code: no change
                  end
               endcase
            end
         end

         SEQ_SCAN: begin
            wr_en = 1'b1;
            if (move_up) begin
               // shift one event up and read the one in front of it
               wr_time   = rd_time;
               wr_length = rd_length;
               wr_kind   = rd_kind;
               ptr_in    = ptr_dec(ptr_ff);
               left_in   = left_ff - 1'b1;
               rd_addr   = ptr_dec(ptr_dec(ptr_ff));
            end else begin
               // insertion point found
               tail_in  = ptr_inc(tail_ff);
               count_in = count_ff + 1'b1;
               state_in = SEQ_FETCH;
            end
         end

         SEQ_FETCH: begin
            state_in = SEQ_LOAD;
         end

         SEQ_LOAD: begin
            if (rsp_free) begin
               rsp_valid_in      = 1'b1;
               rsp_status_in     = status_ff;
               rsp_head_valid_in = (count_ff != '0);
               rsp_time_in       = (count_ff != '0) ? FIELD_WIDTH'(rd_time) : '0;
               rsp_length_in     = (count_ff != '0) ? rd_length : '0;
               rsp_kind_in       = (count_ff != '0) ? rd_kind : '0;
               rsp_count_in      = count_ff;
               state_in          = SEQ_IDLE;
            end
         end

         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.head_valid  = rsp_head_valid_ff;
   assign rsp_chan.head_time   = rsp_time_ff;
   assign rsp_chan.head_length = rsp_length_ff;
   assign rsp_chan.head_kind   = rsp_kind_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

endmodule

// File: rtl/sepq_store.sv
`timescale 1ns / 1ps

module sepq_store #(
   parameter int DEPTH = 16,
   parameter int SW    = 32
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [$clog2(DEPTH)-1:0]           wr_addr,
   input  logic [SW-1:0]                      wr_time,
   input  logic [sepq_pkg::FIELD_WIDTH-1:0]   wr_length,
   input  logic [sepq_pkg::KIND_WIDTH-1:0]    wr_kind,
   input  logic [$clog2(DEPTH)-1:0]           rd_addr,
   output logic [SW-1:0]                      rd_time,
   output logic [sepq_pkg::FIELD_WIDTH-1:0]   rd_length,
   output logic [sepq_pkg::KIND_WIDTH-1:0]    rd_kind
);
   import sepq_pkg::*;

   logic [SW-1:0]          time_mem   [DEPTH];
   logic [FIELD_WIDTH-1:0] length_mem [DEPTH];
   logic [KIND_WIDTH-1:0]  kind_mem   [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[wr_addr]   <= wr_time;
         length_mem[wr_addr] <= wr_length;
         kind_mem[wr_addr]   <= wr_kind;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_time   <= time_mem[rd_addr];
      rd_length <= length_mem[rd_addr];
      rd_kind   <= kind_mem[rd_addr];
   end

endmodule

// File: rtl/sepq_checker.sv
`timescale 1ns / 1ps

module sepq_checker #(
   parameter int DEPTH = 16
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [sepq_pkg::STAT_WIDTH-1:0]    rsp_status,
   input logic                               rsp_head_valid,
   input logic [sepq_pkg::FIELD_WIDTH-1:0]   rsp_head_time,
   input logic [$clog2(DEPTH + 1)-1:0]       rsp_entry_count
);
   import sepq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   // a pending result holds until transferred
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_head_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_head_valid == (rsp_entry_count != '0)))
      else $error("head flag disagrees with count");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_head_valid |-> (rsp_head_time == '0))
      else $error("empty queue reports a head time");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_FULL) |-> (rsp_entry_count == CW'(DEPTH)))
      else $error("push rejected below capacity");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_EMPTY) |-> (rsp_entry_count == '0))
      else $error("pop rejected on non-empty queue");

endmodule

bind sorted_event_priority_queue_unit sepq_checker #(
   .DEPTH (DEPTH)
) u_sepq_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_head_valid  (rsp_chan.head_valid),
   .rsp_head_time   (rsp_chan.head_time),
   .rsp_entry_count (rsp_chan.entry_count)
);

// File: tb/sorted_event_priority_queue_unit_tb.sv
`timescale 1ns / 1ps

module sorted_event_priority_queue_unit_tb;
   import sepq_pkg::*;

   localparam int QUEUE_DEPTH  = 16;
   localparam int TIME_BITS    = 32;
   localparam int COUNT_BITS   = 5;
   localparam int RANDOM_ITEMS = 1950;
   localparam int DRAIN_CYCLES = 40;
   localparam int MAX_REPORTED = 10;

   // command code three is not decoded by the block and must act as a no-op
   localparam logic [CMD_WIDTH-1:0] CMD_UNUSED = 2'd3;

   // traffic shapes for the random part
   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_BALANCED,
      MIX_TIES
   } traffic_mix_type;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]   command;
      logic [FIELD_WIDTH-1:0] event_time;
      logic [FIELD_WIDTH-1:0] event_length;
      logic [KIND_WIDTH-1:0]  event_kind;
   } request_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] event_time;
      logic [FIELD_WIDTH-1:0] event_length;
      logic [KIND_WIDTH-1:0]  event_kind;
   } held_event_type;

   typedef struct packed {
      logic [STAT_WIDTH-1:0]  status;
      logic                   head_valid;
      logic [FIELD_WIDTH-1:0] head_time;
      logic [FIELD_WIDTH-1:0] head_length;
      logic [KIND_WIDTH-1:0]  head_kind;
      logic [COUNT_BITS-1:0]  entry_count;
   } head_report_type;

   // one directed row: the request and, where obvious, the answer typed in
   typedef struct {
      request_type     request;
      bit              typed;
      head_report_type answer;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;

   sepq_req_if                             req_bus ();
   sepq_rsp_if #(.COUNT_WIDTH(COUNT_BITS)) rsp_bus ();

   // shadow copy of the sorted event list, head at index zero
   held_event_type   shadow_events[$];
   // head reports still owed by the block, oldest first
   head_report_type  owed_reports[$];
   // per driven request: typed answer if any, consumed at acceptance
   directed_row_type typed_answers[$];
   directed_row_type directed_rows[$];

   int unsigned mismatch_count = 0;
   int unsigned burst_left     = 0;

   sorted_event_priority_queue_unit #(
      .DEPTH      (QUEUE_DEPTH),
      .TIME_WIDTH (TIME_BITS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #1 clock = ~clock;

   // hard stop in case the block hangs
   initial begin : watchdog
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // apply one accepted request to the shadow list and return the head report
   function automatic head_report_type service_request(input request_type rq);
      head_report_type rep;
      held_event_type  item;
      int unsigned     slot;
      rep = '0;
      rep.status = STAT_OK;
      item = '{rq.event_time, rq.event_length, rq.event_kind};
      case (rq.command)
         CMD_PUSH: begin
            if (shadow_events.size() >= QUEUE_DEPTH) begin
               rep.status = STAT_FULL;
            end else begin
               // ahead of the first entry not earlier than the new one
               slot = 0;
               while (slot < shadow_events.size() &&
                      shadow_events[slot].event_time < rq.event_time) begin
                  slot++;
               end
               shadow_events.insert(slot, item);
            end
         end
         CMD_POP: begin
            if (shadow_events.size() == 0) begin
               rep.status = STAT_EMPTY;
            end else begin
               void'(shadow_events.pop_front());
            end
         end
         CMD_CLEAR: begin
            shadow_events.delete();
         end
         default: begin
         end
      endcase
      if (shadow_events.size() != 0) begin
         rep.head_valid  = 1'b1;
         rep.head_time   = shadow_events[0].event_time;
         rep.head_length = shadow_events[0].event_length;
         rep.head_kind   = shadow_events[0].event_kind;
      end
      rep.entry_count = COUNT_BITS'(shadow_events.size());
      return rep;
   endfunction

   task automatic log_mismatch(input string what, input head_report_type want,
                               input head_report_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTED) begin
         $display("[%0t] %s", $realtime, what);
         $display("   expected: st=%0d hv=%0b t=%h len=%h kind=%h cnt=%0d",
                  want.status, want.head_valid, want.head_time, want.head_length,
                  want.head_kind, want.entry_count);
         $display("   actual:   st=%0d hv=%0b t=%h len=%h kind=%h cnt=%0d",
                  got.status, got.head_valid, got.head_time, got.head_length,
                  got.head_kind, got.entry_count);
      end
   endtask

   // result check first, then prediction of the request accepted at this edge
   always @(posedge clock) begin : check_and_predict
      head_report_type  got;
      head_report_type  want;
      head_report_type  predicted;
      directed_row_type pending;
      request_type      rq;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.status, rsp_bus.head_valid, rsp_bus.head_time,
                    rsp_bus.head_length, rsp_bus.head_kind, rsp_bus.entry_count};
            if (owed_reports.size() == 0) begin
               log_mismatch("result transfer with nothing expected", '0, got);
            end else begin
               want = owed_reports.pop_front();
               if (got.status !== want.status ||
                   got.head_valid !== want.head_valid ||
                   got.head_time !== want.head_time ||
                   got.head_length !== want.head_length ||
                   got.head_kind !== want.head_kind ||
                   got.entry_count !== want.entry_count) begin
                  log_mismatch("head report mismatch", want, got);
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            rq = '{req_bus.command, req_bus.event_time, req_bus.event_length,
                   req_bus.event_kind};
            predicted = service_request(rq);
            // shadow list always advances; a typed answer overrides the prediction
            if (typed_answers.size() != 0) begin
               pending = typed_answers.pop_front();
               owed_reports.push_back(pending.typed ? pending.answer : predicted);
            end else begin
               owed_reports.push_back(predicted);
            end
         end
      end
   end

   // receiver: phases of steady, sparse and alternating ready, with a long
   // hold-off now and then so the block fills up and blocks its input
   initial begin : rsp_stall_pattern
      int unsigned phase_len;
      int unsigned pattern;
      int unsigned hold_cycles;
      int unsigned phase_idx;
      rsp_bus.ready <= 1'b0;
      phase_idx = 0;
      forever begin
         phase_len = $urandom_range(200, 20);
         pattern   = $urandom_range(3, 0);
         if (phase_idx % 6 == 2) begin
            hold_cycles = $urandom_range(90, 50);
            repeat (hold_cycles) begin
               rsp_bus.ready <= 1'b0;
               @(posedge clock);
            end
         end
         for (int c = 0; c < phase_len; c++) begin
            case (pattern)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= ($urandom_range(3, 0) != 0);
               2: rsp_bus.ready <= c[0];
               default: rsp_bus.ready <= ($urandom_range(1, 0) != 0);
            endcase
            @(posedge clock);
         end
         phase_idx++;
      end
   end

   // offer one request until its transfer, then maybe close the burst
   task automatic drive_request(input directed_row_type row);
      int unsigned gap;
      typed_answers.push_back(row);
      req_bus.valid        <= 1'b1;
      req_bus.command      <= row.request.command;
      req_bus.event_time   <= row.request.event_time;
      req_bus.event_length <= row.request.event_length;
      req_bus.event_kind   <= row.request.event_kind;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      if (burst_left == 0) begin
         burst_left = $urandom_range(24, 1);
         // a quarter of the bursts run straight into the next one
         gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   function automatic void add_row(input logic [CMD_WIDTH-1:0] cmd,
                                   input logic [FIELD_WIDTH-1:0] t,
                                   input logic [FIELD_WIDTH-1:0] len,
                                   input logic [KIND_WIDTH-1:0] kind,
                                   input bit typed, input head_report_type answer);
      directed_row_type row;
      row.request = '{cmd, t, len, kind};
      row.typed   = typed;
      row.answer  = answer;
      directed_rows.push_back(row);
   endfunction

   // time keys: mostly full range, some clustered for ties, some extremes
   function automatic logic [FIELD_WIDTH-1:0] pick_time(input traffic_mix_type mix);
      int unsigned roll;
      roll = $urandom_range(99, 0);
      if (mix == MIX_TIES) return $urandom_range(3, 0);
      if (roll < 60) return $urandom;
      if (roll < 85) return $urandom_range(15, 0);
      case ($urandom_range(3, 0))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h7FFF_FFFF;
         default: return 32'h8000_0000;
      endcase
   endfunction

   function automatic directed_row_type random_row(input traffic_mix_type mix);
      directed_row_type  row;
      int unsigned       roll;
      int unsigned       push_cut;
      int unsigned       pop_cut;
      logic [CMD_WIDTH-1:0] cmd;
      roll = $urandom_range(99, 0);
      case (mix)
         MIX_FILL:  begin push_cut = 85; pop_cut = 97; end
         MIX_DRAIN: begin push_cut = 15; pop_cut = 97; end
         MIX_TIES:  begin push_cut = 60; pop_cut = 96; end
         default:   begin push_cut = 48; pop_cut = 94; end
      endcase
      if (roll < push_cut) begin
         cmd = CMD_PUSH;
      end else if (roll < pop_cut) begin
         cmd = CMD_POP;
      end else if (roll < pop_cut + 2) begin
         cmd = CMD_CLEAR;
      end else begin
         cmd = CMD_UNUSED;
      end
      row.request = '{cmd, pick_time(mix), $urandom,
                      KIND_WIDTH'($urandom_range(255, 0))};
      row.typed   = 1'b0;
      row.answer  = '0;
      return row;
   endfunction

   initial begin : stimulus
      head_report_type  empty_ok;
      traffic_mix_type  mix;
      int unsigned      phase_left;
      int unsigned      sent;
      empty_ok = '{STAT_OK, 1'b0, 32'h0, 32'h0, 8'h0, 5'd0};

      // all inputs known from time zero
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.command      <= CMD_PUSH;
      req_bus.event_time   <= '0;
      req_bus.event_length <= '0;
      req_bus.event_kind   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed rows: empty-queue corners, equal-time ordering, full queue
      add_row(CMD_POP, 32'h0, 32'h0, 8'h0, 1'b1,
              '{STAT_EMPTY, 1'b0, 32'h0, 32'h0, 8'h0, 5'd0});
      add_row(CMD_CLEAR, 32'h0, 32'h0, 8'h0, 1'b1, empty_ok);
      add_row(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, empty_ok);
      add_row(CMD_PUSH, 32'h8000_0000, 32'hFFFF_FFFF, 8'hFF, 1'b1,
              '{STAT_OK, 1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 8'hFF, 5'd1});
      add_row(CMD_PUSH, 32'hFFFF_FFFF, 32'h0, 8'h0, 1'b1,
              '{STAT_OK, 1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 8'hFF, 5'd2});
      add_row(CMD_PUSH, 32'h0, 32'h1, 8'h01, 1'b1,
              '{STAT_OK, 1'b1, 32'h0, 32'h1, 8'h01, 5'd3});
      // equal time: the newest event goes in front
      add_row(CMD_PUSH, 32'h0, 32'h2, 8'h02, 1'b1,
              '{STAT_OK, 1'b1, 32'h0, 32'h2, 8'h02, 5'd4});
      add_row(CMD_POP, 32'h0, 32'h0, 8'h0, 1'b0, '0);
      // unused code with a live payload must leave the list alone
      add_row(CMD_UNUSED, 32'h0, 32'hAAAA_5555, 8'h5A, 1'b0, '0);
      // fill to the top, with ties at the head and tail
      for (int i = 0; i < 12; i++) begin
         add_row(CMD_PUSH, 32'h1000_0000 * i + i, 32'h0101_0101 * i,
                 KIND_WIDTH'(8'h11 * i), 1'b0, '0);
      end
      add_row(CMD_PUSH, 32'hFFFF_FFFF, 32'h5555_AAAA, 8'hA5, 1'b0, '0);
      // push on a full queue is dropped
      add_row(CMD_PUSH, 32'h1, 32'h1234_5678, 8'h3C, 1'b0, '0);
      add_row(CMD_POP, 32'h0, 32'h0, 8'h0, 1'b0, '0);
      add_row(CMD_CLEAR, 32'h0, 32'h0, 8'h0, 1'b1, empty_ok);

      foreach (directed_rows[i]) begin
         drive_request(directed_rows[i]);
      end

      // random part in phases of one traffic mix each
      sent       = 0;
      phase_left = 0;
      mix        = MIX_BALANCED;
      while (sent < RANDOM_ITEMS) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(80, 20);
            case ($urandom_range(3, 0))
               0: mix = MIX_FILL;
               1: mix = MIX_DRAIN;
               2: mix = MIX_TIES;
               default: mix = MIX_BALANCED;
            endcase
         end
         drive_request(random_row(mix));
         phase_left--;
         sent++;
      end
      req_bus.valid <= 1'b0;

      // the last transfer is predicted in its own edge, so step past it first
      @(posedge clock);
      // let every owed report come back, then watch for strays
      while (owed_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && owed_reports.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/sepq_pkg.sv
rtl/sepq_req_if.sv
rtl/sepq_rsp_if.sv
rtl/sepq_store.sv
rtl/sorted_event_priority_queue_unit.sv
rtl/sepq_checker.sv
tb/sorted_event_priority_queue_unit_tb.sv
